@@ hw/rtl/cxb_pkg.sv @@
// shared types and constants of the chained xor byte cipher
package cxb_pkg;

	// modulus of the offset chain
	localparam int unsigned MOD_BASE = 255;

	// key bytes the design may use, and key bytes held in the registers
	localparam int unsigned KEY_BYTES     = 32;
	localparam int unsigned KEY_REG_BYTES = 32;
	localparam int unsigned KEY_CAP       = (KEY_BYTES < KEY_REG_BYTES) ? KEY_BYTES
		: KEY_REG_BYTES;

	// depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_DECRYPT_MODE = 3'd0,
		REG_KEY_LENGTH   = 3'd1,
		REG_START_OFFSET = 3'd2,
		REG_KEY_LOW      = 3'd3,
		REG_KEY_SECOND   = 3'd4,
		REG_KEY_THIRD    = 3'd5,
		REG_KEY_HIGH     = 3'd6
	} cxb_reg_t;

	// key bytes, byte 0 lowest
	typedef logic [KEY_REG_BYTES-1:0][7:0] cxb_key_t;

	// mode settings seen by the front
	typedef struct packed {
		logic       decrypt;
		logic [5:0] key_len;
		logic [7:0] start_offset;
	} cxb_cfg_t;

	// one queue entry: an optional header word and one data word
	typedef struct packed {
		logic       hdr;
		logic [7:0] hdr_byte;
		logic [7:0] data;
	} cxb_entry_t;

endpackage

@@ hw/rtl/cxb_front.sv @@
// front: accepts input words, runs the offset chain and key position, queues results
module cxb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  cxb_pkg::cxb_cfg_t   cfg,
	input  cxb_pkg::cxb_key_t   key,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          data_byte,
	input  logic                message_start,
	output logic                push,
	output cxb_pkg::cxb_entry_t push_entry,
	input  logic                queue_ready
);
	import cxb_pkg::*;

	logic [7:0] offset_q;
	logic [4:0] pos_q;

	logic       accept;
	logic [5:0] len;
	logic       enc_start;
	logic [7:0] off_use;
	logic [4:0] pos_base;
	logic [4:0] pos;
	logic [7:0] kb;
	logic [5:0] pos_inc;
	logic [4:0] pos_next;
	logic [8:0] sum;
	logic [8:0] sum_mod;
	logic [7:0] enc_res;
	logic [7:0] t;
	logic [7:0] dec_res;
	logic [7:0] res;

	assign in_ready = queue_ready;
	assign accept   = in_valid && in_ready;

	// effective key length
	assign len = (cfg.key_len > 6'(KEY_CAP)) ? 6'(KEY_CAP) : cfg.key_len;

	// chain offset and key position for this word
	assign enc_start = !cfg.decrypt && message_start;
	assign off_use   = enc_start ? cfg.start_offset : offset_q;
	assign pos_base  = message_start ? 5'd0 : pos_q;
	assign pos       = ({1'b0, pos_base} < len) ? pos_base : 5'd0;
	assign kb        = key[pos];
	assign pos_inc   = {1'b0, pos} + 6'd1;
	assign pos_next  = (pos_inc < len) ? pos_inc[4:0] : 5'd0;

	// encrypt: add modulo 255, then xor key
	assign sum = {1'b0, data_byte} + {1'b0, off_use};
	always_comb begin
		priority if (sum >= 9'(2 * MOD_BASE)) begin
			sum_mod = sum - 9'(2 * MOD_BASE);
		end else if (sum >= 9'(MOD_BASE)) begin
			sum_mod = sum - 9'(MOD_BASE);
		end else begin
			sum_mod = sum;
		end
	end
	assign enc_res = sum_mod[7:0] ^ kb;

	// decrypt: xor key, then subtract offset modulo 255
	assign t       = data_byte ^ kb;
	assign dec_res = (t <= off_use) ? 8'(9'(MOD_BASE) + {1'b0, t} - {1'b0, off_use})
		: (t - off_use);

	assign res = cfg.decrypt ? dec_res : enc_res;

	// queue push: nothing for a zero key length or a decrypt header
	assign push                = accept && (len != 6'd0) && !(cfg.decrypt && message_start);
	assign push_entry.hdr      = enc_start;
	assign push_entry.hdr_byte = cfg.start_offset;
	assign push_entry.data     = res;

	// chain state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= 8'd0;
			pos_q    <= 5'd0;
		end else if (accept && (len != 6'd0)) begin
			if (cfg.decrypt && message_start) begin
				offset_q <= data_byte;
				pos_q    <= 5'd0;
			end else begin
				offset_q <= cfg.decrypt ? data_byte : enc_res;
				pos_q    <= pos_next;
			end
		end
	end

endmodule

@@ hw/rtl/cxb_queue.sv @@
// short first-in first-out queue of result entries between front and back
module cxb_queue #(
	parameter int unsigned DEPTH = cxb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cxb_pkg::cxb_entry_t push_entry,
	output logic                push_ready,
	input  logic                pop,
	output logic                pop_valid,
	output cxb_pkg::cxb_entry_t pop_entry
);
	import cxb_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cxb_entry_t      store_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = store_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push && push_ready) begin
			store_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && push_ready) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop && pop_valid) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push && push_ready, pop && pop_valid})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/cxb_back.sv @@
// back: splits queue entries into output words and holds the output register
module cxb_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                entry_valid,
	input  cxb_pkg::cxb_entry_t entry,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                is_header,
	output logic                last
);
	import cxb_pkg::*;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       is_header_q;
	logic       last_q;
	logic       pend_q;
	logic [7:0] pend_byte_q;
	logic       load;

	assign load      = !out_valid_q || out_ready;
	assign pop       = load && !pend_q && entry_valid;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign is_header = is_header_q;
	assign last      = last_q;

	// output register control and pending data word after a header
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (load) begin
			priority if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (entry_valid) begin
				out_valid_q <= 1'b1;
				pend_q      <= entry.hdr;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (load) begin
			priority if (pend_q) begin
				out_byte_q  <= pend_byte_q;
				is_header_q <= 1'b0;
				last_q      <= 1'b1;
			end else if (entry_valid) begin
				out_byte_q  <= entry.hdr ? entry.hdr_byte : entry.data;
				is_header_q <= entry.hdr;
				last_q      <= !entry.hdr;
				pend_byte_q <= entry.data;
			end
		end
	end

endmodule

@@ hw/rtl/chained_xor_byte_cipher_unit.sv @@
// top level of the chained xor byte cipher with its configuration registers
//
// Byte-stream cipher with a chained offset and a cyclic key of up to 32 bytes.
// Input words arrive on s_axis (tdata: data byte, tuser: message start) and
// result words leave on m_axis (tdata: out byte, tuser: header flag, tlast:
// last word caused by the input word). Registers are written through the
// cfg port (index and 64-bit data, always ready); the user must write them
// only while the stream is idle, which the block does not enforce. An input
// word is taken every cycle while the result queue has room. A word passes
// through the result queue and the output register to m_axis. An encrypt
// message start gives two output words (header, then cipher byte), so the
// output side sets the rate there: one output word per cycle from the output
// register while m_axis is ready. A decrypt header or a zero key length gives
// no output word. When m_axis stalls, the output register holds its word and
// the queue of QUEUE_DEPTH entries fills; s_axis_tready drops once it is full.
// Reset clears the chain offset and key position, empties the queue and
// output register, and restores the registers: encrypt mode, key length 1,
// start offset 0 and an all-zero key.
module chained_xor_byte_cipher_unit #(
	parameter int unsigned QUEUE_DEPTH = cxb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] message_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic        m_axis_tuser,   // [0] is_header
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import cxb_pkg::*;

	logic       decrypt_q;
	logic [5:0] key_len_q;
	logic [7:0] start_offset_q;
	logic [3:0][63:0] key_q;

	cxb_cfg_t   cfg;
	cxb_key_t   key;
	logic       push;
	cxb_entry_t push_entry;
	logic       queue_ready;
	logic       pop;
	logic       pop_valid;
	cxb_entry_t pop_entry;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decrypt_q      <= 1'b0;
			key_len_q      <= 6'd1;
			start_offset_q <= 8'd0;
			key_q          <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DECRYPT_MODE: decrypt_q      <= cfg_data[0];
				REG_KEY_LENGTH:   key_len_q      <= cfg_data[5:0];
				REG_START_OFFSET: start_offset_q <= cfg_data[7:0];
				REG_KEY_LOW:      key_q[0]       <= cfg_data;
				REG_KEY_SECOND:   key_q[1]       <= cfg_data;
				REG_KEY_THIRD:    key_q[2]       <= cfg_data;
				REG_KEY_HIGH:     key_q[3]       <= cfg_data;
				default:          decrypt_q      <= decrypt_q;
			endcase
		end
	end

	assign cfg.decrypt      = decrypt_q;
	assign cfg.key_len      = key_len_q;
	assign cfg.start_offset = start_offset_q;
	assign key              = key_q;

	cxb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.key           (key),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.data_byte     (s_axis_tdata),
		.message_start (s_axis_tuser),
		.push          (push),
		.push_entry    (push_entry),
		.queue_ready   (queue_ready)
	);

	cxb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.push_ready (queue_ready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry)
	);

	cxb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_valid (pop_valid),
		.entry       (pop_entry),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_byte    (m_axis_tdata),
		.is_header   (m_axis_tuser),
		.last        (m_axis_tlast)
	);

endmodule

@@ sim/chained_xor_byte_cipher_unit_tb.sv @@
// testbench of the chained xor byte cipher unit with its own cipher predictor
`timescale 1ns / 100ps

module chained_xor_byte_cipher_unit_tb;
	import cxb_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_CYCLES = 16;

	// one result word as the unit should emit it
	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_header;
		logic       last;
	} cipher_word_t;

	// predicts result words of the cipher and matches them against the unit
	class cipher_expectations;
		bit           decrypt;
		bit [5:0]     key_len;
		bit [7:0]     start_off;
		cxb_key_t     key;
		bit [7:0]     chain;
		bit [4:0]     key_pos;
		cipher_word_t expected_words[$];
		int unsigned  errors;
		int unsigned  bytes_taken;
		int unsigned  words_checked;
		int unsigned  headers_checked;
		int unsigned  reg_writes;

		function new();
			decrypt   = 1'b0;
			key_len   = 6'd1;
			start_off = 8'd0;
			key       = '0;
			chain     = 8'd0;
			key_pos   = 5'd0;
			errors    = 0;
		endfunction

		function void write_reg(cxb_reg_t idx, logic [63:0] value);
			reg_writes++;
			case (idx)
				REG_DECRYPT_MODE: decrypt = value[0];
				REG_KEY_LENGTH:   key_len = value[5:0];
				REG_START_OFFSET: start_off = value[7:0];
				REG_KEY_LOW:      key[7:0] = value;
				REG_KEY_SECOND:   key[15:8] = value;
				REG_KEY_THIRD:    key[23:16] = value;
				REG_KEY_HIGH:     key[31:24] = value;
				default: begin
				end
			endcase
		endfunction

		// advance the chain by one accepted input word
		function void note_byte(logic [7:0] d, logic msg_start);
			int unsigned  len;
			int unsigned  pos;
			int unsigned  t;
			int unsigned  res;
			cipher_word_t w;
			bytes_taken++;
			len = (key_len > KEY_CAP) ? KEY_CAP : key_len;
			// zero key length swallows everything
			if (len == 0)
				return;
			if (decrypt && msg_start) begin
				chain   = d;
				key_pos = 5'd0;
				return;
			end
			if (!decrypt && msg_start) begin
				chain   = start_off;
				key_pos = 5'd0;
				w = '{out_byte: start_off, is_header: 1'b1, last: 1'b0};
				expected_words.push_back(w);
			end
			// a stale position past a shrunk key falls back to byte 0
			pos = (key_pos < len) ? key_pos : 0;
			if (decrypt) begin
				t = d ^ key[pos];
				res = (t <= chain) ? MOD_BASE + t - chain : t - chain;
				chain = d;
			end else begin
				res = ((d + chain) % MOD_BASE) ^ key[pos];
				chain = res[7:0];
			end
			key_pos = 5'((pos + 1 < len) ? pos + 1 : 0);
			w = '{out_byte: res[7:0], is_header: 1'b0, last: 1'b1};
			expected_words.push_back(w);
		endfunction

		function void check_word(logic [7:0] out_byte, logic is_header, logic last);
			cipher_word_t w;
			if (expected_words.size() == 0) begin
				$error("unexpected word: out_byte %02h is_header %0d last %0d",
					out_byte, is_header, last);
				errors++;
				return;
			end
			w = expected_words.pop_front();
			words_checked++;
			if (w.is_header)
				headers_checked++;
			if (out_byte !== w.out_byte) begin
				$error("out_byte: expected %02h, actual %02h", w.out_byte, out_byte);
				errors++;
			end
			if (is_header !== w.is_header) begin
				$error("is_header: expected %0d, actual %0d", w.is_header, is_header);
				errors++;
			end
			if (last !== w.last) begin
				$error("last: expected %0d, actual %0d", w.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] data_byte
	logic        s_axis_tuser;   // [0] message_start
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;   // [7:0] out_byte
	logic        m_axis_tuser;   // [0] is_header
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	cipher_expectations sb;
	int unsigned        tx_idle_pct = 28;
	int unsigned        rx_idle_pct = 65;
	int unsigned        cycles = 0;

	chained_xor_byte_cipher_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// receiver stalls at random
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// watch all three handshakes on pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cxb_reg_t'(cfg_index), cfg_data);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_byte(s_axis_tdata, s_axis_tuser);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
		end
	end

	// offer one input word after a random gap, return once it is taken
	task automatic send_word(input logic [7:0] d, input logic msg_start);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		s_axis_tuser  <= msg_start;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// hold the sender until every expected word has come out
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	// idle the stream fully, then leave room for words still in flight
	task automatic settle();
		drain_results();
		repeat (8) @(posedge clk);
	endtask

	task automatic write_cfg(input cxb_reg_t idx, input logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] pick_key_word();
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [5:0] pick_key_len();
		case ($urandom_range(11))
			0: return 6'd0;
			1: return 6'd1;
			2: return 6'd32;
			3: return 6'($urandom_range(33, 63));
			default: return 6'($urandom_range(2, 31));
		endcase
	endfunction

	function automatic logic [7:0] pick_offset();
		case ($urandom_range(5))
			0: return 8'd0;
			1: return 8'd254;
			2: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	// new random setting, written while idle
	task automatic new_setting(output logic [5:0] len);
		len = pick_key_len();
		write_cfg(REG_DECRYPT_MODE, 64'($urandom_range(1)));
		write_cfg(REG_KEY_LENGTH, 64'(len));
		write_cfg(REG_START_OFFSET, 64'(pick_offset()));
		write_cfg(cxb_reg_t'($urandom_range(REG_KEY_LOW, REG_KEY_HIGH)), pick_key_word());
	endtask

	// mostly whole messages with random content, some stray and empty ones
	task automatic run_messages(input int unsigned n_words);
		int unsigned sent;
		int unsigned body;
		bit          paused;
		sent   = 0;
		paused = 1'b0;
		while (sent < n_words) begin
			if ($urandom_range(99) < 8) begin
				send_word(8'($urandom), 1'b0);
				sent++;
			end else begin
				send_word(8'($urandom), 1'b1);
				body = $urandom_range(0, 24);
				for (int i = 0; i < body; i++)
					send_word(8'($urandom), 1'b0);
				sent += body + 1;
			end
			if (!paused && sent >= n_words / 2) begin
				drain_results();
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		logic [5:0] len;
		sb = new();
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= 1'b0;
		m_axis_tready <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= REG_DECRYPT_MODE;
		cfg_data      <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bytes with no message start since reset, under reset settings
		send_word(8'h00, 1'b0);
		send_word(8'hff, 1'b0);
		settle();

		// encrypt with an all-ones key, offset at its top legal value, sum wraps
		write_cfg(REG_KEY_LOW, '1);
		write_cfg(REG_START_OFFSET, 64'd254);
		send_word(8'hff, 1'b1);
		send_word(8'h00, 1'b0);
		send_word(8'hfe, 1'b0);
		settle();

		// offset 255 as header, then a longer key left at position 4
		write_cfg(REG_START_OFFSET, 64'd255);
		write_cfg(REG_KEY_LOW, {$urandom, $urandom});
		write_cfg(REG_KEY_LENGTH, 64'd5);
		send_word(8'h80, 1'b1);
		send_word(8'h7f, 1'b0);
		send_word(8'h01, 1'b0);
		send_word(8'hfe, 1'b0);
		settle();

		// key shrinks below the current position
		write_cfg(REG_KEY_LENGTH, 64'd2);
		send_word(8'h55, 1'b0);
		send_word(8'haa, 1'b0);
		settle();

		// decrypt with a zero key: equal, above and below the offset
		write_cfg(REG_DECRYPT_MODE, 64'd1);
		write_cfg(REG_KEY_LOW, '0);
		write_cfg(REG_KEY_LENGTH, 64'd1);
		send_word(8'h40, 1'b1);
		send_word(8'h40, 1'b0);
		send_word(8'h41, 1'b0);
		send_word(8'h00, 1'b0);
		settle();

		// oversized key length saturates, upper key words written but not reached
		write_cfg(REG_KEY_LENGTH, 64'd63);
		write_cfg(REG_KEY_SECOND, '1);
		write_cfg(REG_KEY_THIRD, {$urandom, $urandom});
		write_cfg(REG_KEY_HIGH, {$urandom, $urandom});
		send_word(8'hff, 1'b1);
		send_word(8'h00, 1'b0);
		send_word(8'hff, 1'b0);
		settle();

		// zero key length gives nothing at all
		write_cfg(REG_KEY_LENGTH, 64'd0);
		send_word(8'h12, 1'b1);
		send_word(8'h34, 1'b0);
		settle();

		// fresh key material for the random part
		write_cfg(REG_KEY_LOW, {$urandom, $urandom});
		write_cfg(REG_KEY_SECOND, {$urandom, $urandom});
		write_cfg(REG_KEY_THIRD, {$urandom, $urandom});
		write_cfg(REG_KEY_HIGH, {$urandom, $urandom});

		// three idle patterns, several settings each
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 28;
					rx_idle_pct = 65;
				end
				1: begin
					tx_idle_pct = 65;
					rx_idle_pct = 28;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int seg = 0; seg < 4; seg++) begin
				new_setting(len);
				if (len == 0)
					run_messages(16);
				else
					run_messages(140);
				settle();
			end
		end

		// wait out the tail
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d input words and %0d result words (%0d headers)",
			sb.bytes_taken, sb.words_checked, sb.headers_checked);
		$display("across %0d register writes in both modes and three idle patterns",
			sb.reg_writes);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
